// ===== sv/i2c_master_bit_engine_defines.svh =====
// Assertion macros for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

`ifndef SYNTH

// Antecedent true implies consequent true in the same cycle.
`define MBE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent true implies consequent true in the next cycle.
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MBE_ASSERT_SAME(label, clk, rst, ante, cons)
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/i2c_mbe_pkg.sv =====
// Types and constants shared by the I2C master bit engine modules.
package i2c_mbe_pkg;

  // Request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_HOLD  = 2'd0;
  localparam logic [1:0] CFG_BIT_PHASE   = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_HOLD = 2'd2;
  localparam logic [1:0] CFG_ACK_POLL    = 2'd3;

  localparam logic [7:0] START_HOLD_RST  = 8'd4;
  localparam logic [7:0] BIT_PHASE_RST   = 8'd2;
  localparam logic [7:0] SAMPLE_HOLD_RST = 8'd1;
  localparam logic [7:0] ACK_POLL_RST    = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST1   = 5'd1,
    PH_ST2   = 5'd2,
    PH_SP1   = 5'd3,
    PH_SP2   = 5'd4,
    PH_WSET  = 5'd5,
    PH_WHIGH = 5'd6,
    PH_WLOW  = 5'd7,
    PH_AREL  = 5'd8,
    PH_ASET  = 5'd9,
    PH_APOLL = 5'd10,
    PH_RLOW  = 5'd11,
    PH_RHIGH = 5'd12,
    PH_KLOW  = 5'd13,
    PH_KHIGH = 5'd14
  } phase_t;

  typedef struct packed {
    logic [7:0] start_hold_ticks;
    logic [7:0] bit_phase_ticks;
    logic [7:0] sample_hold_ticks;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driven;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
    logic       cmd_ignored;
  } res_t;

endpackage

// ===== sv/i2c_mbe_core.sv =====
// Bit sequencer: state registers and the one-tick next-state logic.
module i2c_mbe_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  i2c_mbe_pkg::cfg_t cfg,
  input  logic [2:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic              send_ack,
  input  logic              sda_in,
  output i2c_mbe_pkg::res_t res
);
  import i2c_mbe_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] poll_count, poll_count_next;
  logic       ack_choice, ack_choice_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       sda_drive_reg, sda_drive_reg_next;
  logic [7:0] rx_reg, rx_reg_next;
  logic       timeout, timeout_next;

  logic       is_cmd;
  logic       elap;
  logic [7:0] tick_dec;
  logic [3:0] bit_inc;
  logic       more_bits;
  logic [7:0] shift_up;
  logic       poll_over;
  logic       done, err, ignored;

  assign is_cmd    = req_type inside {[REQ_START:REQ_READ]};
  assign elap      = (tick_count <= 8'd1);
  assign tick_dec  = elap ? 8'd0 : tick_count - 8'd1;
  assign bit_inc   = bit_index + 4'd1;
  assign more_bits = (bit_inc < BITS_PER_BYTE);
  assign shift_up  = {shift_reg[6:0], 1'b0};
  assign poll_over = (poll_count >= cfg.ack_poll_limit);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (is_cmd) begin
          case (req_type)
            REQ_START: phase_next = PH_ST1;
            REQ_STOP:  phase_next = PH_SP1;
            REQ_WRITE: phase_next = PH_WSET;
            default:   phase_next = PH_RLOW;
          endcase
        end
      end
      PH_ST1:   if (elap) phase_next = PH_ST2;
      PH_ST2:   if (elap) phase_next = PH_IDLE;
      PH_SP1:   if (elap) phase_next = PH_SP2;
      PH_SP2:   if (elap) phase_next = PH_IDLE;
      PH_WSET:  if (elap) phase_next = PH_WHIGH;
      PH_WHIGH: if (elap) phase_next = PH_WLOW;
      PH_WLOW:  if (elap) phase_next = more_bits ? PH_WSET : PH_AREL;
      PH_AREL:  if (elap) phase_next = PH_ASET;
      PH_ASET:  if (elap) phase_next = PH_APOLL;
      PH_APOLL: begin
        if (!sda_in) phase_next = PH_IDLE;
        else if (poll_over) phase_next = PH_SP1;
      end
      PH_RLOW:  if (elap) phase_next = PH_RHIGH;
      PH_RHIGH: if (elap) phase_next = more_bits ? PH_RLOW : PH_KLOW;
      PH_KLOW:  if (elap) phase_next = PH_KHIGH;
      PH_KHIGH: if (elap) phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  // Datapath, line levels and status
  always_comb begin
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    poll_count_next    = poll_count;
    ack_choice_next    = ack_choice;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    sda_drive_reg_next = sda_drive_reg;
    rx_reg_next        = rx_reg;
    timeout_next       = timeout;
    done               = 1'b0;
    err                = 1'b0;
    ignored            = 1'b0;
    if (phase == PH_IDLE) begin
      if (is_cmd) begin
        timeout_next = 1'b0;
        case (req_type)
          REQ_START: begin
            sda_drive_reg_next = 1'b1;
            sda_reg_next       = 1'b1;
            scl_reg_next       = 1'b1;
            tick_count_next    = cfg.start_hold_ticks;
          end
          REQ_STOP: begin
            sda_drive_reg_next = 1'b1;
            sda_reg_next       = 1'b0;
            scl_reg_next       = 1'b0;
            tick_count_next    = cfg.start_hold_ticks;
          end
          REQ_WRITE: begin
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b0;
            shift_reg_next     = tx_byte;
            bit_index_next     = 4'd0;
            sda_reg_next       = tx_byte[7];
            tick_count_next    = cfg.bit_phase_ticks;
          end
          default: begin
            sda_drive_reg_next = 1'b0;
            ack_choice_next    = send_ack;
            shift_reg_next     = 8'd0;
            bit_index_next     = 4'd0;
            scl_reg_next       = 1'b0;
            tick_count_next    = cfg.bit_phase_ticks;
          end
        endcase
      end
    end else begin
      ignored = is_cmd;
      if (phase != PH_APOLL) tick_count_next = tick_dec;
      case (phase)
        PH_ST1: begin
          if (elap) begin
            sda_reg_next    = 1'b0;
            tick_count_next = cfg.start_hold_ticks;
          end
        end
        PH_ST2: begin
          if (elap) begin
            scl_reg_next = 1'b0;
            done         = 1'b1;
          end
        end
        PH_SP1: begin
          if (elap) begin
            scl_reg_next    = 1'b1;
            sda_reg_next    = 1'b1;
            tick_count_next = cfg.start_hold_ticks;
          end
        end
        PH_SP2: begin
          if (elap) begin
            done         = 1'b1;
            err          = timeout;
            timeout_next = 1'b0;
          end
        end
        PH_WSET: begin
          if (elap) begin
            scl_reg_next    = 1'b1;
            tick_count_next = cfg.bit_phase_ticks;
          end
        end
        PH_WHIGH: begin
          if (elap) begin
            scl_reg_next    = 1'b0;
            tick_count_next = cfg.bit_phase_ticks;
          end
        end
        PH_WLOW: begin
          if (elap) begin
            shift_reg_next = shift_up;
            bit_index_next = bit_inc;
            if (more_bits) begin
              sda_reg_next    = shift_up[7];
              tick_count_next = cfg.bit_phase_ticks;
            end else begin
              sda_drive_reg_next = 1'b0;
              sda_reg_next       = 1'b1;
              tick_count_next    = cfg.sample_hold_ticks;
            end
          end
        end
        PH_AREL: begin
          if (elap) begin
            scl_reg_next    = 1'b1;
            tick_count_next = cfg.sample_hold_ticks;
          end
        end
        PH_ASET: begin
          if (elap) poll_count_next = 8'd0;
        end
        PH_APOLL: begin
          if (!sda_in) begin
            scl_reg_next = 1'b0;
            done         = 1'b1;
          end else if (poll_over) begin
            // timeout: drive a stop, flag the error when it completes
            timeout_next       = 1'b1;
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b0;
            sda_reg_next       = 1'b0;
            tick_count_next    = cfg.start_hold_ticks;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        PH_RLOW: begin
          if (elap) begin
            scl_reg_next    = 1'b1;
            shift_reg_next  = {shift_reg[6:0], sda_in};
            tick_count_next = cfg.sample_hold_ticks;
          end
        end
        PH_RHIGH: begin
          if (elap) begin
            bit_index_next  = bit_inc;
            scl_reg_next    = 1'b0;
            tick_count_next = cfg.bit_phase_ticks;
            if (!more_bits) begin
              rx_reg_next        = shift_reg;
              sda_drive_reg_next = 1'b1;
              sda_reg_next       = !ack_choice;
            end
          end
        end
        PH_KLOW: begin
          if (elap) begin
            scl_reg_next    = 1'b1;
            tick_count_next = cfg.bit_phase_ticks;
          end
        end
        PH_KHIGH: begin
          if (elap) begin
            scl_reg_next = 1'b0;
            done         = 1'b1;
          end
        end
        default: tick_count_next = tick_count;
      endcase
    end
  end

  always_comb begin
    res.scl_level   = scl_reg_next;
    res.sda_level   = sda_reg_next;
    res.sda_driven  = sda_drive_reg_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_reg_next;
    res.ack_error   = err;
    res.cmd_ignored = ignored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= 8'd0;
      bit_index     <= 4'd0;
      shift_reg     <= 8'd0;
      poll_count    <= 8'd0;
      ack_choice    <= 1'b0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      sda_drive_reg <= 1'b1;
      rx_reg        <= 8'd0;
      timeout       <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      poll_count    <= poll_count_next;
      ack_choice    <= ack_choice_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      sda_drive_reg <= sda_drive_reg_next;
      rx_reg        <= rx_reg_next;
      timeout       <= timeout_next;
    end
  end

endmodule

// ===== sv/i2c_mbe_outreg.sv =====
// Result register with valid/stall handshake toward the consumer.
module i2c_mbe_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  i2c_mbe_pkg::res_t res_in,
  input  logic              out_stall,
  output logic              out_valid,
  output i2c_mbe_pkg::res_t res_out
);
  import i2c_mbe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== sv/i2c_master_bit_engine.sv =====
// I2C master bit engine top level: config registers, handshake, sequencer, result register.
`include "i2c_master_bit_engine_defines.svh"

// I2C master bit engine. Each input word is one timing tick carrying the sampled SDA level
// and an optional command (start, stop, write byte, read byte); each tick yields exactly one
// result word with the SCL/SDA levels, busy, done, received byte and status flags. The engine
// takes one tick per clock cycle unless in_stall is high: the whole step runs in one pass of
// combinational logic from the state registers into the result register, and the result
// appears in the cycle after the tick is taken. A new tick is taken while the previous result
// is drained in the same cycle; input stall is high only while a held result is itself stalled.
// Config writes on cfg_we: lengths apply from the next phase entry, the poll limit on each poll.
module i2c_master_bit_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       sda_driven,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_error,
  output logic       cmd_ignored
);
  import i2c_mbe_pkg::*;

  cfg_t cfg;
  res_t step_res;
  res_t held_res;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_hold_ticks  <= START_HOLD_RST;
      cfg.bit_phase_ticks   <= BIT_PHASE_RST;
      cfg.sample_hold_ticks <= SAMPLE_HOLD_RST;
      cfg.ack_poll_limit    <= ACK_POLL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_HOLD:  cfg.start_hold_ticks  <= cfg_data;
        CFG_BIT_PHASE:   cfg.bit_phase_ticks   <= cfg_data;
        CFG_SAMPLE_HOLD: cfg.sample_hold_ticks <= cfg_data;
        CFG_ACK_POLL:    cfg.ack_poll_limit    <= cfg_data;
        default:         cfg.ack_poll_limit    <= cfg.ack_poll_limit;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  i2c_mbe_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .cfg      (cfg),
    .req_type (req_type),
    .tx_byte  (tx_byte),
    .send_ack (send_ack),
    .sda_in   (sda_in),
    .res      (step_res)
  );

  i2c_mbe_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (held_res)
  );

  assign scl_level   = held_res.scl_level;
  assign sda_level   = held_res.sda_level;
  assign sda_driven  = held_res.sda_driven;
  assign busy_res    = held_res.busy_res;
  assign done_res    = held_res.done_res;
  assign rx_byte     = held_res.rx_byte;
  assign ack_error   = held_res.ack_error;
  assign cmd_ignored = held_res.cmd_ignored;

  // a completed command leaves the engine idle
  `MBE_ASSERT_SAME(a_done_idle, clk, rst, out_valid && done_res, !busy_res)
  // ack error only reported on the completing word
  `MBE_ASSERT_SAME(a_err_done, clk, rst, out_valid && ack_error, done_res)
  // a taken tick always lands in the result register
  `MBE_ASSERT_NEXT(a_accept_out, clk, rst, accept, out_valid)
  // back-pressure only comes from a held result
  `MBE_ASSERT_SAME(a_stall_src, clk, rst, in_stall, out_valid)

endmodule

// ===== tb/bit_engine_monitor.sv =====
// Monitor for the I2C bit engine: tracks the engine state per tick word and checks each result.
module bit_engine_monitor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       scl_level,
  input  logic       sda_level,
  input  logic       sda_driven,
  input  logic       busy_res,
  input  logic       done_res,
  input  logic [7:0] rx_byte,
  input  logic       ack_error,
  input  logic       cmd_ignored,
  output logic       engine_busy,
  output int         words_pending,
  output int         mismatch_count
);
  import i2c_mbe_pkg::*;

  cfg_t       cfg_q;
  phase_t     eng_phase;
  logic [7:0] tick_left;
  logic [3:0] bit_idx;
  logic [7:0] shifter;
  logic [7:0] polls;
  logic       ack_sel;
  logic       scl_q;
  logic       sda_q;
  logic       drv_q;
  logic [7:0] rx_q;
  logic       timeout_flag;

  res_t pending_bus_states[$];

  // Counts down the current phase; true on its last tick. A length of 0 behaves as 1.
  function automatic logic phase_over();
    if (tick_left > 8'd1) begin
      tick_left = tick_left - 8'd1;
      return 1'b0;
    end
    tick_left = 8'd0;
    return 1'b1;
  endfunction

  task automatic enter_phase(input phase_t next_phase, input logic [7:0] len);
    eng_phase = next_phase;
    tick_left = len;
  endtask

  task automatic launch_stop();
    drv_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    enter_phase(PH_SP1, cfg_q.start_hold_ticks);
  endtask

  task automatic advance_engine(input logic [2:0] req, input logic [7:0] tx, input logic sack,
                                input logic sda, output res_t r);
    logic is_cmd;
    logic fin;
    logic err;
    logic drop;
    is_cmd = (req >= REQ_START) && (req <= REQ_READ);
    fin = 1'b0;
    err = 1'b0;
    drop = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (is_cmd) begin
        timeout_flag = 1'b0;
        case (req)
          REQ_START: begin
            drv_q = 1'b1;
            sda_q = 1'b1;
            scl_q = 1'b1;
            enter_phase(PH_ST1, cfg_q.start_hold_ticks);
          end
          REQ_STOP: launch_stop();
          REQ_WRITE: begin
            drv_q = 1'b1;
            scl_q = 1'b0;
            shifter = tx;
            bit_idx = 4'd0;
            sda_q = tx[7];
            enter_phase(PH_WSET, cfg_q.bit_phase_ticks);
          end
          default: begin
            drv_q = 1'b0;
            ack_sel = sack;
            shifter = 8'd0;
            bit_idx = 4'd0;
            scl_q = 1'b0;
            enter_phase(PH_RLOW, cfg_q.bit_phase_ticks);
          end
        endcase
      end
    end else begin
      drop = is_cmd;
      case (eng_phase)
        PH_ST1: if (phase_over()) begin
          sda_q = 1'b0;
          enter_phase(PH_ST2, cfg_q.start_hold_ticks);
        end
        PH_ST2: if (phase_over()) begin
          scl_q = 1'b0;
          eng_phase = PH_IDLE;
          fin = 1'b1;
        end
        PH_SP1: if (phase_over()) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          enter_phase(PH_SP2, cfg_q.start_hold_ticks);
        end
        PH_SP2: if (phase_over()) begin
          eng_phase = PH_IDLE;
          fin = 1'b1;
          err = timeout_flag;
          timeout_flag = 1'b0;
        end
        PH_WSET: if (phase_over()) begin
          scl_q = 1'b1;
          enter_phase(PH_WHIGH, cfg_q.bit_phase_ticks);
        end
        PH_WHIGH: if (phase_over()) begin
          scl_q = 1'b0;
          enter_phase(PH_WLOW, cfg_q.bit_phase_ticks);
        end
        PH_WLOW: if (phase_over()) begin
          shifter = shifter << 1;
          bit_idx = bit_idx + 4'd1;
          if (bit_idx < BITS_PER_BYTE) begin
            sda_q = shifter[7];
            enter_phase(PH_WSET, cfg_q.bit_phase_ticks);
          end else begin
            // release SDA for the slave ack
            drv_q = 1'b0;
            sda_q = 1'b1;
            enter_phase(PH_AREL, cfg_q.sample_hold_ticks);
          end
        end
        PH_AREL: if (phase_over()) begin
          scl_q = 1'b1;
          enter_phase(PH_ASET, cfg_q.sample_hold_ticks);
        end
        PH_ASET: if (phase_over()) begin
          polls = 8'd0;
          eng_phase = PH_APOLL;
        end
        PH_APOLL: begin
          if (!sda) begin
            scl_q = 1'b0;
            eng_phase = PH_IDLE;
            fin = 1'b1;
          end else if (polls >= cfg_q.ack_poll_limit) begin
            timeout_flag = 1'b1;
            launch_stop();
          end else begin
            polls = polls + 8'd1;
          end
        end
        PH_RLOW: if (phase_over()) begin
          scl_q = 1'b1;
          shifter = {shifter[6:0], sda};
          enter_phase(PH_RHIGH, cfg_q.sample_hold_ticks);
        end
        PH_RHIGH: if (phase_over()) begin
          bit_idx = bit_idx + 4'd1;
          scl_q = 1'b0;
          if (bit_idx < BITS_PER_BYTE) begin
            enter_phase(PH_RLOW, cfg_q.bit_phase_ticks);
          end else begin
            rx_q = shifter;
            drv_q = 1'b1;
            sda_q = !ack_sel;
            enter_phase(PH_KLOW, cfg_q.bit_phase_ticks);
          end
        end
        PH_KLOW: if (phase_over()) begin
          scl_q = 1'b1;
          enter_phase(PH_KHIGH, cfg_q.bit_phase_ticks);
        end
        PH_KHIGH: if (phase_over()) begin
          scl_q = 1'b0;
          eng_phase = PH_IDLE;
          fin = 1'b1;
        end
        default: eng_phase = PH_IDLE;
      endcase
    end
    r.scl_level   = scl_q;
    r.sda_level   = sda_q;
    r.sda_driven  = drv_q;
    r.busy_res    = (eng_phase != PH_IDLE);
    r.done_res    = fin;
    r.rx_byte     = rx_q;
    r.ack_error   = err;
    r.cmd_ignored = drop;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : track
    res_t fresh;
    res_t want;
    if (rst) begin
      cfg_q = {START_HOLD_RST, BIT_PHASE_RST, SAMPLE_HOLD_RST, ACK_POLL_RST};
      eng_phase = PH_IDLE;
      tick_left = 8'd0;
      bit_idx = 4'd0;
      shifter = 8'd0;
      polls = 8'd0;
      ack_sel = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drv_q = 1'b1;
      rx_q = 8'd0;
      timeout_flag = 1'b0;
      mismatch_count = 0;
      pending_bus_states.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_HOLD:  cfg_q.start_hold_ticks = cfg_data;
          CFG_BIT_PHASE:   cfg_q.bit_phase_ticks = cfg_data;
          CFG_SAMPLE_HOLD: cfg_q.sample_hold_ticks = cfg_data;
          CFG_ACK_POLL:    cfg_q.ack_poll_limit = cfg_data;
          default:         cfg_q = cfg_q;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_engine(req_type, tx_byte, send_ack, sda_in, fresh);
        pending_bus_states.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        if (pending_bus_states.size() == 0) begin
          $display("%0t: result word with nothing predicted", $time);
          mismatch_count++;
        end else begin
          want = pending_bus_states.pop_front();
          check_bit("scl_level", want.scl_level, scl_level);
          check_bit("sda_level", want.sda_level, sda_level);
          check_bit("sda_driven", want.sda_driven, sda_driven);
          check_bit("busy_res", want.busy_res, busy_res);
          check_bit("done_res", want.done_res, done_res);
          check_field("rx_byte", want.rx_byte, rx_byte);
          check_bit("ack_error", want.ack_error, ack_error);
          check_bit("cmd_ignored", want.cmd_ignored, cmd_ignored);
        end
      end
    end
    engine_busy <= (eng_phase != PH_IDLE);
    words_pending <= pending_bus_states.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the I2C bit engine test: clock, reset, tick stimulus, config phases and verdict.
module testbench;
  import i2c_mbe_pkg::*;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // SDA behavior seen by one command
  localparam int SDA_RANDOM      = 0;
  localparam int SDA_MOSTLY_HIGH = 1;
  localparam int SDA_STUCK_HIGH  = 2;
  localparam int SDA_STUCK_LOW   = 3;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_START_HOLD;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] req_type = REQ_TICK;
  logic [7:0] tx_byte = 8'd0;
  logic       send_ack = 1'b0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       sda_driven;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;
  logic       cmd_ignored;

  logic engine_busy;
  int   words_pending;
  int   fail_count;

  int sender_idle_pct = 23;
  int receiver_stall_pct = 50;
  int words_sent = 0;

  i2c_master_bit_engine DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .tx_byte(tx_byte), .send_ack(send_ack), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_level(scl_level), .sda_level(sda_level), .sda_driven(sda_driven),
    .busy_res(busy_res), .done_res(done_res), .rx_byte(rx_byte),
    .ack_error(ack_error), .cmd_ignored(cmd_ignored)
  );

  bit_engine_monitor monitor (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .tx_byte(tx_byte), .send_ack(send_ack), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_level(scl_level), .sda_level(sda_level), .sda_driven(sda_driven),
    .busy_res(busy_res), .done_res(done_res), .rx_byte(rx_byte),
    .ack_error(ack_error), .cmd_ignored(cmd_ignored),
    .engine_busy(engine_busy), .words_pending(words_pending), .mismatch_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic logic is_command(input logic [2:0] req);
    return (req >= REQ_START) && (req <= REQ_READ);
  endfunction

  function automatic logic line_level(input int sda_mode);
    case (sda_mode)
      SDA_RANDOM:      return 1'($urandom_range(1));
      SDA_MOSTLY_HIGH: return ($urandom_range(9) != 0);
      SDA_STUCK_HIGH:  return 1'b1;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic int pick_sda_mode();
    int r;
    r = $urandom_range(99);
    if (r < 40) return SDA_RANDOM;
    if (r < 65) return SDA_MOSTLY_HIGH;
    if (r < 80) return SDA_STUCK_HIGH;
    return SDA_STUCK_LOW;
  endfunction

  // Returns at the edge where the word is taken.
  task automatic push_tick(input logic [2:0] req, input logic [7:0] tx, input logic ack,
                           input logic sda);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    tx_byte <= tx;
    send_ack <= ack;
    sda_in <= sda;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Issue a command on an idle engine and tick until it is idle again.
  // engine_busy lags one word, so idle is known only after a non-command on an idle engine.
  task automatic run_command(input logic [2:0] req, input logic [7:0] tx, input logic ack,
                             input int sda_mode, input int noise_pct);
    logic [2:0] filler;
    push_tick(req, tx, ack, line_level(sda_mode));
    do begin
      if ($urandom_range(99) < noise_pct)
        filler = 3'($urandom_range(REQ_START, REQ_UNUSED_HI));
      else
        filler = REQ_TICK;
      push_tick(filler, 8'($urandom), 1'($urandom_range(1)), line_level(sda_mode));
    end while (engine_busy || is_command(filler));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic apply_setting(input logic [7:0] hold_len, input logic [7:0] bit_len,
                               input logic [7:0] sample_len, input logic [7:0] poll_max);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_HOLD;
    cfg_data <= hold_len;
    @(posedge clk);
    cfg_index <= CFG_BIT_PHASE;
    cfg_data <= bit_len;
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_HOLD;
    cfg_data <= sample_len;
    @(posedge clk);
    cfg_index <= CFG_ACK_POLL;
    cfg_data <= poll_max;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int first;
    int r;
    first = words_sent;
    while (words_sent - first < count) begin
      r = $urandom_range(99);
      if (r < 5) begin
        push_tick(REQ_TICK, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < 8) begin
        push_tick(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 8'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < 15) begin
        // stray command outside a start/stop frame
        run_command(3'($urandom_range(REQ_START, REQ_READ)), 8'($urandom),
                    1'($urandom_range(1)), pick_sda_mode(), 4);
      end else begin
        run_command(REQ_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 4);
        repeat ($urandom_range(1, 3))
          run_command($urandom_range(1) ? REQ_WRITE : REQ_READ, 8'($urandom),
                      1'($urandom_range(1)), pick_sda_mode(), 4);
        run_command(REQ_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 4);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset timing
    run_command(REQ_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(REQ_WRITE, 8'hFF, 1'b0, SDA_STUCK_LOW, 0);
    run_command(REQ_WRITE, 8'h00, 1'b1, SDA_STUCK_HIGH, 0);
    run_command(REQ_WRITE, 8'hA5, 1'b0, SDA_MOSTLY_HIGH, 0);
    run_command(REQ_READ, 8'h00, 1'b1, SDA_STUCK_HIGH, 0);
    run_command(REQ_READ, 8'hFF, 1'b0, SDA_STUCK_LOW, 0);
    run_command(REQ_READ, 8'h5A, 1'b1, SDA_RANDOM, 25);
    run_command(REQ_STOP, 8'h00, 1'b0, SDA_RANDOM, 25);
    for (int u = REQ_UNUSED_LO; u <= REQ_UNUSED_HI; u++)
      push_tick(3'(u), 8'hFF, 1'b1, 1'b0);
    push_tick(REQ_TICK, 8'h3C, 1'b0, 1'b1);
    run_command(REQ_START, 8'hC3, 1'b1, SDA_RANDOM, 40);

    drain_results();
    apply_setting(8'd1, 8'd1, 8'd1, 8'd1);
    run_random(120);

    sender_idle_pct = 50;
    receiver_stall_pct <= 23;
    drain_results();
    // zero lengths act as one, zero poll limit times out on the first high poll
    apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
    run_random(120);

    sender_idle_pct = 0;
    receiver_stall_pct <= 0;
    repeat (2) begin
      drain_results();
      apply_setting(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                    8'($urandom_range(1, 3)), 8'($urandom_range(0, 6)));
      run_random(50);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
